// ----- src/hvt_pkg.sv -----
`default_nettype none
package hvt_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW = 2 * CoordW;
  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned NumW = SumW + FracBits;
  localparam int unsigned QW = NumW;
  localparam int unsigned QCntW = $clog2(QW + 1);
  localparam int unsigned FifoDepth = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [SumW-1:0] s0;
    logic signed [SumW-1:0] s1;
    logic signed [SumW-1:0] s2;
    logic signed [SumW-1:0] s3;
  } sums_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic w_zero;
    logic sat;
  } res_t;

  localparam logic [CoordW-1:0] One = CoordW'(1) << FracBits;
endpackage
`default_nettype wire

// ----- src/hvt_front.sv -----
`default_nettype none
// Matrix store, products and sums; two stages, one point per cycle while the sums output is not stalled.
module hvt_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic op_i,
  input  wire logic [3:0] entry_index_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] entry_value_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] point_y_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] point_z_i,
  output logic sums_valid_o,
  input  wire logic sums_ready_i,
  output hvt_pkg::sums_t sums_o
);
  logic signed [hvt_pkg::CoordW-1:0] m_q [16];
  logic signed [hvt_pkg::ProdW-1:0] p_q [12];
  logic signed [hvt_pkg::CoordW-1:0] t_q [4];
  logic v1_q, v2_q, adv1, adv2;
  hvt_pkg::sums_t s_q;

  assign adv2 = !v2_q || sums_ready_i;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign sums_valid_o = v2_q;
  assign sums_o = s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        m_q[i] <= (i % 5 == 0) ? hvt_pkg::One : '0;
      end
    end else if (in_valid_i && in_ready_o && op_i == hvt_pkg::OP_LOAD) begin
      m_q[entry_index_i] <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i && op_i == hvt_pkg::OP_XFORM;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int j = 0; j < 4; j++) begin
        p_q[j] <= point_x_i * m_q[j];
        p_q[4+j] <= point_y_i * m_q[4+j];
        p_q[8+j] <= point_z_i * m_q[8+j];
        t_q[j] <= m_q[12+j];
      end
    end
    if (adv2) begin
      s_q.s0 <= hvt_pkg::SumW'(p_q[0]) + hvt_pkg::SumW'(p_q[4]) + hvt_pkg::SumW'(p_q[8])
              + (hvt_pkg::SumW'(t_q[0]) <<< hvt_pkg::FracBits);
      s_q.s1 <= hvt_pkg::SumW'(p_q[1]) + hvt_pkg::SumW'(p_q[5]) + hvt_pkg::SumW'(p_q[9])
              + (hvt_pkg::SumW'(t_q[1]) <<< hvt_pkg::FracBits);
      s_q.s2 <= hvt_pkg::SumW'(p_q[2]) + hvt_pkg::SumW'(p_q[6]) + hvt_pkg::SumW'(p_q[10])
              + (hvt_pkg::SumW'(t_q[2]) <<< hvt_pkg::FracBits);
      s_q.s3 <= hvt_pkg::SumW'(p_q[3]) + hvt_pkg::SumW'(p_q[7]) + hvt_pkg::SumW'(p_q[11])
              + (hvt_pkg::SumW'(t_q[3]) <<< hvt_pkg::FracBits);
    end
  end
endmodule
`default_nettype wire

// ----- src/hvt_fifo.sv -----
`default_nettype none
module hvt_fifo (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic wr_ready_o,
  input  wire hvt_pkg::sums_t wr_data_i,
  output logic rd_valid_o,
  input  wire logic rd_ready_i,
  output hvt_pkg::sums_t rd_data_o
);
  hvt_pkg::sums_t mem_q [hvt_pkg::FifoDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 2'(hvt_pkg::FifoDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wr_data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

// ----- src/hvt_back.sv -----
`default_nettype none
// Three restoring dividers sharing one w, one quotient bit per cycle.
module hvt_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic sums_valid_i,
  output logic sums_ready_o,
  input  wire hvt_pkg::sums_t sums_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output hvt_pkg::res_t res_o
);
  localparam int unsigned N = hvt_pkg::NumW;
  localparam int unsigned W = hvt_pkg::CoordW;
  logic busy_q, ov_q, ov_d;
  logic [hvt_pkg::QCntW-1:0] cnt_q;
  logic [N-1:0] n_q [3];
  logic [N-1:0] q_q [3];
  logic [N:0] r_q [3];
  logic neg_q [3];
  logic [N-1:0] d_q;
  logic wz_q;
  hvt_pkg::res_t res_q, fin;
  logic [hvt_pkg::SumW-1:0] sv [3];
  logic [hvt_pkg::SumW-1:0] wabs;
  logic [N:0] rs [3];
  logic done, fin_ld;

  assign sums_ready_o = !busy_q;
  assign out_valid_o = ov_q;
  assign res_o = res_q;
  assign done = busy_q && cnt_q == '0;
  // Hand the result over once the output register is free or being emptied.
  assign fin_ld = done && (!ov_q || out_ready_i);
  assign ov_d = fin_ld || (ov_q && !out_ready_i);
  assign sv[0] = sums_i.s0;
  assign sv[1] = sums_i.s1;
  assign sv[2] = sums_i.s2;
  assign wabs = sums_i.s3[hvt_pkg::SumW-1] ? -sums_i.s3 : sums_i.s3;

  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] c [3];
    logic neg, st;
    st = 1'b0;
    for (int k = 0; k < 3; k++) begin
      rs[k] = {r_q[k][N-1:0], n_q[k][N-1]};
      neg = neg_q[k] && q_q[k] != '0;
      lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      if (q_q[k][N-1:W] != '0 || q_q[k][W-1:0] > lim) begin
        st = 1'b1;
        c[k] = neg ? lim : lim;
      end else begin
        c[k] = neg ? -q_q[k][W-1:0] : q_q[k][W-1:0];
      end
      if (wz_q) c[k] = '0;
    end
    fin.x = c[0];
    fin.y = c[1];
    fin.z = c[2];
    fin.w_zero = wz_q;
    fin.sat = st && !wz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      ov_q <= ov_d;
      if (sums_valid_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q <= hvt_pkg::QCntW'(N);
      end else if (busy_q && cnt_q != '0) begin
        cnt_q <= cnt_q - hvt_pkg::QCntW'(1);
      end else if (fin_ld) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sums_valid_i && !busy_q) begin
      d_q <= N'(wabs);
      wz_q <= sums_i.s3 == '0;
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= N'(sv[k][hvt_pkg::SumW-1] ? -sv[k] : sv[k]) << hvt_pkg::FracBits;
        neg_q[k] <= sv[k][hvt_pkg::SumW-1] ^ sums_i.s3[hvt_pkg::SumW-1];
        q_q[k] <= '0;
        r_q[k] <= '0;
      end
    end else if (busy_q && cnt_q != '0) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= n_q[k] << 1;
        if (rs[k] >= {1'b0, d_q}) begin
          r_q[k] <= rs[k] - {1'b0, d_q};
          q_q[k] <= {q_q[k][N-2:0], 1'b1};
        end else begin
          r_q[k] <= rs[k];
          q_q[k] <= {q_q[k][N-2:0], 1'b0};
        end
      end
    end
    if (fin_ld) res_q <= fin;
  end
endmodule
`default_nettype wire

// ----- src/homogeneous_vertex_transform.sv -----
`default_nettype none
// Channel | Direction | Fields
// in      | input     | op, entry_index, entry_value, point_x/y/z
// out     | output    | out_x, out_y, out_z, w_zero, saturated
// Loads are taken one per cycle unless the front stalls; a transform passes two
// product/sum stages, then a bit-serial divider that takes no new point until the
// last one is handed on, which sets the point rate.
// Reset loads the identity matrix at once; no clearing pass.
// A two-entry queue holds sums while the divider is busy; output waits in a register.
module homogeneous_vertex_transform (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic op_i,
  input  wire logic [3:0] entry_index_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] entry_value_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] point_y_i,
  input  wire logic signed [hvt_pkg::CoordW-1:0] point_z_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [hvt_pkg::CoordW-1:0] out_x_o,
  output logic signed [hvt_pkg::CoordW-1:0] out_y_o,
  output logic signed [hvt_pkg::CoordW-1:0] out_z_o,
  output logic w_zero_o,
  output logic saturated_o
);
  logic fv, fr, bv, br;
  hvt_pkg::sums_t fs, bs;
  hvt_pkg::res_t res;

  hvt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .entry_index_i, .entry_value_i,
    .point_x_i, .point_y_i, .point_z_i,
    .sums_valid_o(fv), .sums_ready_i(fr), .sums_o(fs)
  );
  hvt_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fs),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bs)
  );
  hvt_back u_back (
    .clk_i, .rst_ni, .sums_valid_i(bv), .sums_ready_o(br), .sums_i(bs),
    .out_valid_o, .out_ready_i, .res_o(res)
  );

  assign out_x_o = res.x;
  assign out_y_o = res.y;
  assign out_z_o = res.z;
  assign w_zero_o = res.w_zero;
  assign saturated_o = res.sat;

  a_wz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_zero_o |-> out_x_o == '0 && out_y_o == '0 && !saturated_o)
    else $error("w zero result not cleared");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o))
    else $error("result changed under stall");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned IdleLimit = 20000;
  localparam logic signed [hvt_pkg::CoordW-1:0] MaxCoord =
      {1'b0, {(hvt_pkg::CoordW-1){1'b1}}};
  localparam logic signed [hvt_pkg::CoordW-1:0] MinCoord =
      {1'b1, {(hvt_pkg::CoordW-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = hvt_pkg::OP_LOAD;
  logic [3:0] entry_index_i = '0;
  logic signed [hvt_pkg::CoordW-1:0] entry_value_i = '0;
  logic signed [hvt_pkg::CoordW-1:0] point_x_i = '0;
  logic signed [hvt_pkg::CoordW-1:0] point_y_i = '0;
  logic signed [hvt_pkg::CoordW-1:0] point_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [hvt_pkg::CoordW-1:0] out_x_o, out_y_o, out_z_o;
  logic w_zero_o, saturated_o;

  homogeneous_vertex_transform i_dut (.*);

  always #5 clk_i = ~clk_i;

  logic signed [hvt_pkg::CoordW-1:0] model_matrix [16];
  hvt_pkg::res_t expected_vertices [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned gap_cycles = 0;
  int unsigned sink_idle_max = 3;
  int unsigned source_idle_max = 3;

  function automatic void reset_matrix();
    for (int i = 0; i < 16; i++) model_matrix[i] = (i % 5 == 0) ? hvt_pkg::One : '0;
  endfunction

  // Divide num << FracBits by den, truncated toward zero, then clip.
  function automatic logic signed [hvt_pkg::CoordW-1:0] divide_clip(
      logic signed [hvt_pkg::SumW-1:0] num, logic signed [hvt_pkg::SumW-1:0] den,
      inout bit sat);
    logic signed [hvt_pkg::NumW+1:0] n, d, q;
    n = hvt_pkg::NumW'(num) <<< hvt_pkg::FracBits;
    d = den;
    q = n / d;
    if (q > MaxCoord) begin
      sat = 1'b1;
      return MaxCoord;
    end
    if (q < MinCoord) begin
      sat = 1'b1;
      return MinCoord;
    end
    return q[hvt_pkg::CoordW-1:0];
  endfunction

  function automatic hvt_pkg::res_t project_vertex(logic signed [hvt_pkg::CoordW-1:0] px,
      logic signed [hvt_pkg::CoordW-1:0] py, logic signed [hvt_pkg::CoordW-1:0] pz);
    logic signed [hvt_pkg::SumW-1:0] s [4];
    logic signed [hvt_pkg::CoordW-1:0] p [4];
    hvt_pkg::res_t r;
    bit sat;
    p[0] = px; p[1] = py; p[2] = pz; p[3] = hvt_pkg::One;
    sat = 1'b0;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      s[j] = '0;
      for (int k = 0; k < 4; k++)
        s[j] += hvt_pkg::SumW'(p[k]) * hvt_pkg::SumW'(model_matrix[k*4+j]);
    end
    if (s[3] == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    r.x = divide_clip(s[0], s[3], sat);
    r.y = divide_clip(s[1], s[3], sat);
    r.z = divide_clip(s[2], s[3], sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [hvt_pkg::CoordW-1:0] got,
      logic [hvt_pkg::CoordW-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  // Drop valid only when the pause is not empty.
  task automatic pause_source();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10 * source_idle_max)
                                     : $urandom_range(0, source_idle_max);
    if (n != 0) in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one transaction and hold it until taken; predict on acceptance.
  task automatic send_item(hvt_pkg::op_e op, logic [3:0] idx,
      logic signed [hvt_pkg::CoordW-1:0] val,
      logic signed [hvt_pkg::CoordW-1:0] px, logic signed [hvt_pkg::CoordW-1:0] py,
      logic signed [hvt_pkg::CoordW-1:0] pz);
    in_valid_i <= 1'b1;
    op_i <= op;
    entry_index_i <= idx;
    entry_value_i <= val;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == hvt_pkg::OP_LOAD) model_matrix[idx] = val;
    else expected_vertices.push_back(project_vertex(px, py, pz));
    if (source_idle_max > 0 && $urandom_range(0, 1)) pause_source();
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  task automatic load_entry(logic [3:0] idx, logic signed [hvt_pkg::CoordW-1:0] val);
    send_item(hvt_pkg::OP_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic transform_point(logic signed [hvt_pkg::CoordW-1:0] px,
      logic signed [hvt_pkg::CoordW-1:0] py, logic signed [hvt_pkg::CoordW-1:0] pz);
    send_item(hvt_pkg::OP_XFORM, 4'($urandom), $urandom, px, py, pz);
  endtask

  task automatic wait_drained();
    end_burst();
    while (expected_vertices.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [hvt_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MaxCoord : MinCoord;
      1: return $signed(hvt_pkg::CoordW'($urandom_range(0, 8))) * hvt_pkg::One;
      2: return -($signed(hvt_pkg::CoordW'($urandom_range(0, 8))) * hvt_pkg::One);
      3: return $signed(hvt_pkg::CoordW'($urandom_range(0, 1 << 20))) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_identity_extremes();
    transform_point('0, '0, '0);
    transform_point(MaxCoord, MinCoord, hvt_pkg::One);
    transform_point(MinCoord, MaxCoord, -hvt_pkg::One);
    transform_point('1, 32'sh5555_aaaa, 32'shaaaa_5555);
    load_entry(4'd15, 32'sh0000_8000);
    transform_point(MaxCoord, hvt_pkg::One, -hvt_pkg::One);
    load_entry(4'd15, -hvt_pkg::One);
    transform_point(MinCoord, 32'sh1234_5678, '1);
    load_entry(4'd15, '0);
    transform_point(hvt_pkg::One, hvt_pkg::One, hvt_pkg::One);
    load_entry(4'd3, hvt_pkg::One);
    transform_point(-hvt_pkg::One, '0, '0);
    transform_point('0, '0, '0);
    load_entry(4'd3, '0);
    load_entry(4'd15, hvt_pkg::One);
    wait_drained();
  endtask

  task automatic test_random_stream(int unsigned n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 7) == 0)
        load_entry(4'($urandom), $urandom_range(0, 3) == 0 ? rand_coord() :
                   $signed(hvt_pkg::CoordW'($urandom_range(0, 4 << hvt_pkg::FracBits)))
                   - (2 << hvt_pkg::FracBits));
      else
        transform_point(rand_coord(), rand_coord(), rand_coord());
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    source_idle_max = 0;
    hold_off_cycles = 600;
    for (int i = 0; i < 8; i++) transform_point(rand_coord(), rand_coord(), rand_coord());
    source_idle_max = 3;
    wait_drained();
  endtask

  // Receiver: random stalls, a few long gaps, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (gap_cycles != 0) begin
      gap_cycles <= gap_cycles - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      gap_cycles <= $urandom_range(20, 80);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < sink_idle_max);
    end
  end

  always @(posedge clk_i) begin
    hvt_pkg::res_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t unexpected result", $time);
        error_count++;
      end else begin
        want = expected_vertices.pop_front();
        if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
        if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
        if (out_z_o !== want.z) report_mismatch("out_z", out_z_o, want.z);
        if (w_zero_o !== want.w_zero) report_mismatch("w_zero", w_zero_o, want.w_zero);
        if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    reset_matrix();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_extremes();
    test_back_pressure();
    sink_idle_max = 40;
    test_random_stream(880);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_vertices.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- homogeneous_vertex_transform.f -----
src/hvt_pkg.sv
src/hvt_front.sv
src/hvt_fifo.sv
src/hvt_back.sv
src/homogeneous_vertex_transform.sv
tb/testbench.sv
